// ===== hw/rtl/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

    localparam int HEAP_BYTES_DEF  = 32768;
    localparam int CHUNK_BYTES_DEF = 4096;
    localparam int NEED_W          = 17;
    localparam int OFS_W           = 15;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_ZERO = 2'd1,
        STS_BIG  = 2'd2,
        STS_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic        cmd;
        logic [15:0] request_bytes;
        logic [14:0] block_offset;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] payload_offset;
    } t_out;

endpackage

// ===== hw/rtl/ffha_ram.sv =====
// Heap word memory: one write port, one registered read port.
module ffha_ram import ffha_pkg::*; #(
    parameter int WW = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [WW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [WW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] mem [2**WW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
// Allocator sequencer: block walk, extend, merge, split and result register.
module ffha_ctrl import ffha_pkg::*; #(
    parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int BW          = $clog2(HEAP_BYTES) + 1,
    parameter int WW          = BW - 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in           i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_out          o_out,
    output logic          o_we,
    output logic [WW-1:0] o_waddr,
    output logic [31:0]   o_wdata,
    output logic [WW-1:0] o_raddr,
    input  logic [31:0]   i_rdata
);

    localparam int CW = (BW > OFS_W) ? BW : OFS_W;

    typedef enum logic [20:0] {
        S_INIT    = 21'd1 << 0,
        S_IDLE    = 21'd1 << 1,
        S_FIT_RD  = 21'd1 << 2,
        S_FIT_CHK = 21'd1 << 3,
        S_FIT_END = 21'd1 << 4,
        S_EXT_W0  = 21'd1 << 5,
        S_EXT_W1  = 21'd1 << 6,
        S_EXT_W2  = 21'd1 << 7,
        S_MRG_RDP = 21'd1 << 8,
        S_MRG_RDN = 21'd1 << 9,
        S_MRG_CHK = 21'd1 << 10,
        S_MRG_W0  = 21'd1 << 11,
        S_MRG_W1  = 21'd1 << 12,
        S_PLC_W0  = 21'd1 << 13,
        S_PLC_W1  = 21'd1 << 14,
        S_PLC_W2  = 21'd1 << 15,
        S_PLC_W3  = 21'd1 << 16,
        S_FREE_RD = 21'd1 << 17,
        S_FREE_CK = 21'd1 << 18,
        S_FREE_W0 = 21'd1 << 19,
        S_DONE    = 21'd1 << 20
    } t_state;

    t_state        r_state, n_state;
    logic [2:0]    r_init, n_init;
    logic [BW-1:0] r_bp, n_bp;
    logic [BW-1:0] r_sz, n_sz;
    logic [BW-1:0] r_need, n_need;
    logic [BW-1:0] r_brk, n_brk;
    logic [CW-1:0] r_tgt, n_tgt;
    logic          r_alloc, n_alloc;
    logic [31:0]   r_prev, n_prev;
    t_status       r_sts, n_sts;
    logic          r_ov, n_ov;
    t_out          r_out, n_out;

    logic [BW-1:0]     rd_sz, prev_sz, rem, psz;
    logic [BW-1:0]     waddr_b, raddr_b;
    logic              split;
    logic [NEED_W-1:0] need17;
    logic [BW:0]       ext_end;

    function automatic logic [BW-1:0] size_of(input logic [31:0] w);
        return {w[BW-1:3], 3'b000};
    endfunction

    assign rd_sz   = size_of(i_rdata);
    assign prev_sz = size_of(r_prev);
    assign rem     = r_sz - r_need;
    assign split   = rem >= BW'(16);
    assign psz     = split ? r_need : r_sz;
    assign need17  = ((NEED_W'(i_in.request_bytes) + NEED_W'(7)) & ~NEED_W'(7)) + NEED_W'(8);
    assign ext_end = {1'b0, r_brk} + {1'b0, r_need};

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign o_waddr     = waddr_b[WW+1:2];
    assign o_raddr     = raddr_b[WW+1:2];

    always_comb begin
        o_we    = 1'b0;
        waddr_b = '0;
        o_wdata = '0;
        raddr_b = '0;
        case (r_state)
            S_INIT: begin
                o_we = 1'b1;
                case (r_init)
                    3'd0: begin
                        waddr_b = BW'(4);
                        o_wdata = 32'd9;
                    end
                    3'd1: begin
                        waddr_b = BW'(8);
                        o_wdata = 32'd9;
                    end
                    3'd2: begin
                        waddr_b = BW'(12);
                        o_wdata = 32'(CHUNK_BYTES);
                    end
                    3'd3: begin
                        waddr_b = BW'(CHUNK_BYTES + 8);
                        o_wdata = 32'(CHUNK_BYTES);
                    end
                    default: begin
                        waddr_b = BW'(CHUNK_BYTES + 12);
                        o_wdata = 32'd1;
                    end
                endcase
            end
            S_FIT_RD, S_FREE_RD: raddr_b = r_bp - BW'(4);
            S_EXT_W0, S_MRG_W0, S_FREE_W0: begin
                o_we    = 1'b1;
                waddr_b = r_bp - BW'(4);
                o_wdata = 32'(r_state == S_EXT_W0 ? r_need : r_sz);
            end
            S_EXT_W1: begin
                o_we    = 1'b1;
                waddr_b = r_bp + r_need - BW'(8);
                o_wdata = 32'(r_need);
            end
            S_EXT_W2: begin
                o_we    = 1'b1;
                waddr_b = r_bp + r_need - BW'(4);
                o_wdata = 32'd1;
            end
            S_MRG_RDP: raddr_b = r_bp - BW'(8);
            S_MRG_RDN: raddr_b = r_bp + r_sz - BW'(4);
            S_MRG_W1: begin
                o_we    = 1'b1;
                waddr_b = r_bp + r_sz - BW'(8);
                o_wdata = 32'(r_sz);
            end
            S_PLC_W0: begin
                o_we    = 1'b1;
                waddr_b = r_bp - BW'(4);
                o_wdata = 32'(psz) | 32'd1;
            end
            S_PLC_W1: begin
                o_we    = 1'b1;
                waddr_b = r_bp + psz - BW'(8);
                o_wdata = 32'(psz) | 32'd1;
            end
            S_PLC_W2: begin
                o_we    = 1'b1;
                waddr_b = r_bp + r_need - BW'(4);
                o_wdata = 32'(rem);
            end
            S_PLC_W3: begin
                o_we    = 1'b1;
                waddr_b = r_bp + r_sz - BW'(8);
                o_wdata = 32'(rem);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        n_bp    = r_bp;
        n_sz    = r_sz;
        n_need  = r_need;
        n_brk   = r_brk;
        n_tgt   = r_tgt;
        n_alloc = r_alloc;
        n_prev  = r_prev;
        n_sts   = r_sts;
        n_ov    = r_ov && i_out_stall;
        n_out   = r_out;
        case (r_state)
            S_INIT: begin
                n_init = r_init + 3'd1;
                if (r_init == 3'd4) begin
                    n_brk   = BW'(CHUNK_BYTES + 16);
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_bp    = BW'(16);
                    n_sts   = STS_OK;
                    n_tgt   = CW'(i_in.block_offset);
                    n_alloc = (i_in.cmd == CMD_ALLOC);
                    n_need  = BW'(need17);
                    if (i_in.cmd == CMD_FREE) begin
                        n_state = S_FREE_RD;
                    end else if (i_in.request_bytes == 16'd0) begin
                        n_sts   = STS_ZERO;
                        n_state = S_DONE;
                    end else if (need17 > NEED_W'(CHUNK_BYTES)) begin
                        n_sts   = STS_BIG;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FIT_RD;
                    end
                end
            end
            S_FIT_RD: n_state = (r_bp >= r_brk) ? S_FIT_END : S_FIT_CHK;
            S_FIT_CHK: begin
                if (rd_sz == '0) begin
                    n_state = S_FIT_END;
                end else if (!i_rdata[0] && rd_sz >= r_need) begin
                    n_sz    = rd_sz;
                    n_state = S_PLC_W0;
                end else begin
                    n_bp    = r_bp + rd_sz;
                    n_state = S_FIT_RD;
                end
            end
            S_FIT_END: begin
                if (ext_end > (BW+1)'(HEAP_BYTES)) begin
                    n_sts   = STS_FULL;
                    n_state = S_DONE;
                end else begin
                    n_bp    = r_brk;
                    n_state = S_EXT_W0;
                end
            end
            S_EXT_W0: n_state = S_EXT_W1;
            S_EXT_W1: n_state = S_EXT_W2;
            S_EXT_W2: begin
                n_brk   = ext_end[BW-1:0];
                n_sz    = r_need;
                n_state = S_MRG_RDP;
            end
            S_MRG_RDP: n_state = S_MRG_RDN;
            S_MRG_RDN: begin
                n_prev  = i_rdata;
                n_state = S_MRG_CHK;
            end
            S_MRG_CHK: begin
                if (r_prev[0] && i_rdata[0]) begin
                    n_state = r_alloc ? S_PLC_W0 : S_MRG_W1;
                end else begin
                    n_sz = r_sz + (i_rdata[0] ? '0 : rd_sz) + (r_prev[0] ? '0 : prev_sz);
                    n_bp = r_bp - (r_prev[0] ? '0 : prev_sz);
                    n_state = S_MRG_W0;
                end
            end
            S_MRG_W0: n_state = S_MRG_W1;
            S_MRG_W1: n_state = r_alloc ? S_PLC_W0 : S_DONE;
            S_PLC_W0: n_state = S_PLC_W1;
            S_PLC_W1: n_state = split ? S_PLC_W2 : S_DONE;
            S_PLC_W2: n_state = S_PLC_W3;
            S_PLC_W3: n_state = S_DONE;
            S_FREE_RD: begin
                if (r_bp >= r_brk || CW'(r_bp) > r_tgt) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FREE_CK;
                end
            end
            S_FREE_CK: begin
                if (rd_sz == '0) begin
                    n_state = S_DONE;
                end else if (CW'(r_bp) == r_tgt) begin
                    n_sz    = rd_sz;
                    n_state = i_rdata[0] ? S_FREE_W0 : S_DONE;
                end else begin
                    n_bp    = r_bp + rd_sz;
                    n_state = S_FREE_RD;
                end
            end
            S_FREE_W0: n_state = S_MRG_RDP;
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov                 = 1'b1;
                    n_out.status         = r_sts;
                    n_out.payload_offset = (r_alloc && r_sts == STS_OK) ?
                                           OFS_W'(r_bp) : '0;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_ov    <= 1'b0;
            r_brk   <= '0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_ov    <= n_ov;
            r_brk   <= n_brk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bp    <= n_bp;
        r_sz    <= n_sz;
        r_need  <= n_need;
        r_tgt   <= n_tgt;
        r_alloc <= n_alloc;
        r_prev  <= n_prev;
        r_sts   <= n_sts;
        r_out   <= n_out;
    end

endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator with boundary tags over one heap word memory.
//
// An allocate or free transaction walks the block list from the first block,
// reading one header word per block from the heap memory's single read port.
// An allocate then may end the walk, extend the heap, merge with the block
// before, split and register its result; a free retags the block, merges
// with both neighbors and registers its result. Zero-size and oversize
// requests go straight to the result. After reset the block writes the
// initial tags before it takes its first transaction. One transaction is in
// work at a time; the result register lets the next one start while a
// result still waits.
module first_fit_heap_allocator import ffha_pkg::*; #(
    parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int BW = $clog2(HEAP_BYTES) + 1;
    localparam int WW = BW - 3;

    logic          we;
    logic [WW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    ffha_ctrl #(
        .HEAP_BYTES (HEAP_BYTES),
        .CHUNK_BYTES(CHUNK_BYTES),
        .BW         (BW),
        .WW         (WW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    ffha_ram #(
        .WW(WW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

endmodule

// ===== hw/rtl/ffha_checker.sv =====
// Port-level checks of the heap allocator and their binding.
module ffha_checker import ffha_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != STS_OK |-> o_out.payload_offset == '0)
        else $error("failed request carries an offset");

    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.payload_offset[2:0] == 3'b000)
        else $error("payload offset not aligned");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while busy");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in       (i_in),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out      (o_out)
);

// ===== tb/tb.sv =====
// Testbench for the first-fit heap allocator: directed and random transactions.
`timescale 1ns / 1ps
module tb;
    import ffha_pkg::*;

    localparam int HEAP_BYTES  = 32768;
    localparam int CHUNK_BYTES = 4096;
    localparam int HEAP_WORDS  = HEAP_BYTES / 4;
    localparam int FIRST_PL    = 16;
    localparam int MIN_BLK     = 16;
    localparam longint CYCLE_LIMIT = 20000000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    first_fit_heap_allocator #(.HEAP_BYTES(HEAP_BYTES), .CHUNK_BYTES(CHUNK_BYTES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_in(i_in), .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    logic [31:0] heap_mem [HEAP_WORDS];
    int unsigned brk;
    t_out        pending_results[$];
    int unsigned live_blocks[$];
    int          fail_count;
    longint      cycle_count;
    bit          hold_off;
    int          hold_cycles;
    bit          stall_enable;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [31:0] hrd(int unsigned b);
        return (b / 4 < HEAP_WORDS) ? heap_mem[b / 4] : 32'd0;
    endfunction

    function automatic void hwr(int unsigned b, logic [31:0] v);
        if (b / 4 < HEAP_WORDS) heap_mem[b / 4] = v;
    endfunction

    function automatic int unsigned bsize(int unsigned bp);
        return hrd(bp - 4) & ~32'd7;
    endfunction

    function automatic bit balloc(int unsigned bp);
        return hrd(bp - 4) & 32'd1;
    endfunction

    function automatic void tag(int unsigned bp, int unsigned sz, bit al);
        hwr(bp - 4, sz | al);
        hwr(bp + sz - 8, sz | al);
    endfunction

    function automatic int unsigned coalesce(int unsigned bp);
        int unsigned sz, psz, nsz;
        bit pa, na;
        sz  = bsize(bp);
        pa  = hrd(bp - 8) & 32'd1;
        psz = hrd(bp - 8) & ~32'd7;
        na  = balloc(bp + sz);
        nsz = bsize(bp + sz);
        if (pa && na) return bp;
        if (!na) sz += nsz;
        if (!pa) begin
            sz += psz;
            bp -= psz;
        end
        tag(bp, sz, 1'b0);
        return bp;
    endfunction

    function automatic int unsigned first_free_block(int unsigned need);
        int unsigned bp, s;
        bp = FIRST_PL;
        while (bp < brk) begin
            s = bsize(bp);
            if (s == 0) return 0;
            if (!balloc(bp) && s >= need) return bp;
            bp += s;
        end
        return 0;
    endfunction

    function automatic bit is_live(int unsigned t);
        int unsigned bp, s;
        bp = FIRST_PL;
        while (bp < brk) begin
            s = bsize(bp);
            if (s == 0 || bp > t) return 0;
            if (bp == t) return balloc(bp);
            bp += s;
        end
        return 0;
    endfunction

    function automatic void heap_reset();
        foreach (heap_mem[i]) heap_mem[i] = 32'd0;
        hwr(4, 32'd9);
        hwr(8, 32'd9);
        tag(FIRST_PL, CHUNK_BYTES, 1'b0);
        hwr(FIRST_PL + CHUNK_BYTES - 4, 32'd1);
        brk = FIRST_PL + CHUNK_BYTES;
    endfunction

    function automatic t_out heap_apply(t_in x);
        t_out r;
        int unsigned sz, need, bp, s;
        r = '0;
        if (x.cmd == CMD_ALLOC) begin
            sz   = x.request_bytes;
            need = 8 + ((sz + 7) & ~32'd7);
            if (sz == 0) r.status = STS_ZERO;
            else if (need > CHUNK_BYTES) r.status = STS_BIG;
            else begin
                bp = first_free_block(need);
                if (bp == 0) begin
                    if (brk + need > HEAP_BYTES) r.status = STS_FULL;
                    else begin
                        bp = brk;
                        tag(bp, need, 1'b0);
                        hwr(bp + need - 4, 32'd1);
                        brk += need;
                        bp = coalesce(bp);
                    end
                end
                if (r.status == STS_OK) begin
                    s = bsize(bp);
                    if (s - need >= MIN_BLK) begin
                        tag(bp, need, 1'b1);
                        tag(bp + need, s - need, 1'b0);
                    end else begin
                        tag(bp, s, 1'b1);
                    end
                    r.payload_offset = bp[14:0];
                    live_blocks.push_back(bp);
                end
            end
        end else begin
            bp = x.block_offset;
            if (is_live(bp)) begin
                tag(bp, bsize(bp), 1'b0);
                void'(coalesce(bp));
            end
        end
        return r;
    endfunction

    task automatic send_request(t_in x);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) gap = 1;
        repeat (gap) @(posedge i_clk);
        i_in       <= x;
        i_in_valid <= 1'b1;
        pending_results.push_back(heap_apply(x));
        do @(posedge i_clk); while (o_in_stall);
        i_in_valid <= 1'b0;
    endtask

    task automatic send_alloc(int unsigned sz);
        t_in x;
        x = '0;
        x.cmd = CMD_ALLOC;
        x.request_bytes = sz[15:0];
        x.block_offset = 15'($urandom());
        send_request(x);
    endtask

    task automatic send_free(int unsigned ofs);
        t_in x;
        x = '0;
        x.cmd = CMD_FREE;
        x.block_offset = ofs[14:0];
        x.request_bytes = 16'($urandom());
        send_request(x);
    endtask

    task automatic free_random_live();
        int k;
        int unsigned ofs;
        if (live_blocks.size() == 0) return;
        k = $urandom_range(0, live_blocks.size() - 1);
        ofs = live_blocks[k];
        live_blocks.delete(k);
        send_free(ofs);
    endtask

    task automatic test_directed();
        send_alloc(0);
        send_alloc(16'hFFFF);
        send_alloc(CHUNK_BYTES - 7);
        send_alloc(CHUNK_BYTES - 8);
        send_alloc(1);
        send_alloc(8);
        send_alloc(9);
        send_free(live_blocks[1]);
        send_free(live_blocks[1]);
        send_free(8);
        send_free(0);
        send_free(17);
        send_free(15'h7FFF);
        send_alloc(1);
        send_alloc(2);
        send_free(live_blocks[0]);
        live_blocks.delete(0);
    endtask

    task automatic test_fill_heap();
        repeat (12) send_alloc(CHUNK_BYTES - 8);
        while (live_blocks.size() > 0) free_random_live();
    endtask

    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if ($urandom_range(0, 9) == 0) send_alloc($urandom_range(1, CHUNK_BYTES - 8));
                else send_alloc($urandom_range(1, 200));
            end else if (r < 85) begin
                free_random_live();
            end else if (r < 92) begin
                send_free($urandom_range(0, 32767));
            end else begin
                send_alloc($urandom_range(0, 65535));
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        hold_off = 1'b1;
        repeat (20) send_alloc($urandom_range(1, 64));
        wait (!hold_off);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_off) begin
            i_out_stall <= 1'b1;
            if (hold_cycles == 0) hold_off <= 1'b0;
            else hold_cycles <= hold_cycles - 1;
        end else if (!stall_enable) begin
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
            i_out_stall <= 1'b1;
        end else if (i_out_stall && $urandom_range(0, 3) != 0) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 4) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result status=%0d payload_offset=%0d",
                       o_out.status, o_out.payload_offset);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_out.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_out.status);
                    fail_count++;
                end
                if (o_out.payload_offset !== e.payload_offset) begin
                    $error("payload_offset expected %0d actual %0d",
                           e.payload_offset, o_out.payload_offset);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_stall  = 1'b0;
        fail_count   = 0;
        cycle_count  = 0;
        hold_off     = 1'b0;
        hold_cycles  = 0;
        stall_enable = 1'b1;
        heap_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_heap();
        test_backpressure();
        stall_enable = 1'b0;
        test_random(150);
        stall_enable = 1'b1;
        test_random(850);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== first_fit_heap_allocator.f =====
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ram.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator.sv
hw/rtl/ffha_checker.sv
tb/tb.sv
